>>> rtl/bmv_pkg.sv
`timescale 1ns / 1ps
package bmv_pkg;

  localparam int MAX_ROWS      = 1024;
  localparam int MAX_HALF_BAND = 7;
  localparam int BAND_STRIDE   = 2 * MAX_HALF_BAND + 1;
  localparam int BAND_DEPTH    = MAX_ROWS * BAND_STRIDE;
  localparam int BAND_AW       = $clog2(BAND_DEPTH);

  localparam int ROW_W   = 10;
  localparam int DIAG_W  = 4;
  localparam int HB_W    = 3;
  localparam int RC_W    = 11;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + $clog2(BAND_STRIDE) + 1;
  localparam int FRAC_W  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RC_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BAND = 2'd1;

  localparam logic [1:0] MODE_VEC  = 2'd0;
  localparam logic [1:0] MODE_BAND = 2'd1;
  localparam logic [1:0] MODE_ROW  = 2'd2;

  localparam logic [1:0] OP_VEC  = 2'd0;
  localparam logic [1:0] OP_BAND = 2'd1;
  localparam logic [1:0] OP_ROW  = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]              mode;
    logic [ROW_W-1:0]        index;
    logic [DIAG_W-1:0]       diagonal;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_number;
    logic signed [VAL_W-1:0] product_sum;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ROW_W-1:0]  row;
    logic [DIAG_W-1:0] diag;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [RC_W-1:0] row_count;
    logic [HB_W-1:0] half_band;
  } cfg_t;

endpackage

>>> rtl/bmv_ram.sv
`timescale 1ns / 1ps
module bmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/bmv_front.sv
`timescale 1ns / 1ps
module bmv_front (
  input  bmv_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          full,
  output logic          push,
  output bmv_pkg::req_t req
);
  import bmv_pkg::*;

  logic keep;

  // index is ROW_W wide, so it always lands inside the stores
  always_comb begin
    req.row   = in_data.index;
    req.diag  = in_data.diagonal;
    req.value = in_data.value;
    req.op    = OP_VEC;
    keep      = 1'b0;
    unique case (in_data.mode)
      MODE_VEC: begin
        req.op = OP_VEC;
        keep   = 1'b1;
      end
      MODE_BAND: begin
        req.op = OP_BAND;
        keep   = (32'(in_data.diagonal) < BAND_STRIDE);
      end
      MODE_ROW: begin
        req.op = OP_ROW;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !full;
  assign push     = in_valid && !full && keep;
endmodule

>>> rtl/bmv_fifo.sv
`timescale 1ns / 1ps
module bmv_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bmv_pkg::req_t push_req,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output bmv_pkg::req_t q_req
);
  import bmv_pkg::*;

  req_t            slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign full    = (count == (QA_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

>>> rtl/bmv_back.sv
`timescale 1ns / 1ps
module bmv_back (
  input  logic          clk,
  input  logic          rst,
  input  bmv_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  bmv_pkg::req_t q_req,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output bmv_pkg::out_t out_data
);
  import bmv_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state;
  logic [ROW_W-1:0]        row;
  logic [DIAG_W-1:0]       k;
  logic                    v1;
  logic                    v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [ROW_W+1:0] col;
  logic                    col_ok;
  logic [DIAG_W-1:0]       k_last;
  logic [BAND_AW-1:0]      band_waddr;
  logic [BAND_AW-1:0]      band_raddr;
  logic [VAL_W-1:0]        vec_rd;
  logic [VAL_W-1:0]        band_rd;
  logic                    vec_we;
  logic                    band_we;
  logic                    issue;
  logic                    load;

  logic signed [ACC_W-FRAC_W-1:0] quot;
  logic [ACC_W-FRAC_W-VAL_W:0]    top_bits;
  logic                           fits;
  logic [VAL_W-1:0]               clipped;

  assign k_last = {1'b0, cfg.half_band} << 1;
  assign col    = (ROW_W+2)'(row) + (ROW_W+2)'(k) - (ROW_W+2)'(cfg.half_band);
  assign col_ok = !col[ROW_W+1] && ((ROW_W+2)'(col) < (ROW_W+2)'(cfg.row_count));

  // band entry (row, k) sits at row * stride + k
  assign band_waddr = BAND_AW'(BAND_AW'(q_req.row) * BAND_AW'(BAND_STRIDE))
                    + BAND_AW'(q_req.diag);
  assign band_raddr = BAND_AW'(BAND_AW'(row) * BAND_AW'(BAND_STRIDE)) + BAND_AW'(k);

  assign pop     = (state == S_IDLE) && q_valid;
  assign vec_we  = pop && (q_req.op == OP_VEC);
  assign band_we = pop && (q_req.op == OP_BAND);
  assign issue   = (state == S_ISSUE);
  assign load    = (state == S_DONE) && (!out_valid || out_ready);

  bmv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (q_req.row),
    .wdata (q_req.value),
    .raddr (col[ROW_W-1:0]),
    .rdata (vec_rd)
  );

  bmv_ram #(.WIDTH(VAL_W), .DEPTH(BAND_DEPTH)) u_band_ram (
    .clk   (clk),
    .we    (band_we),
    .waddr (band_waddr),
    .wdata (q_req.value),
    .raddr (band_raddr),
    .rdata (band_rd)
  );

  // floor by 2^16 is the arithmetic shift; clip when upper bits differ from sign
  always_comb begin
    quot     = acc[ACC_W-1:FRAC_W];
    top_bits = quot[ACC_W-FRAC_W-1:VAL_W-1];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      clipped = quot[VAL_W-1:0];
    end else if (quot[ACC_W-FRAC_W-1]) begin
      clipped = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      clipped = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(band_rd) * $signed(vec_rd);
    if (pop && (q_req.op == OP_ROW)) begin
      row <= q_req.row;
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (load) begin
      out_data.row_number  <= row;
      out_data.product_sum <= clipped;
      out_data.saturated   <= !fits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue && col_ok;
      v2 <= v1;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && (q_req.op == OP_ROW)) begin
            k     <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          k <= k + 1'b1;
          if (k == k_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

>>> rtl/banded_matrix_vector_product.sv
`timescale 1ns / 1ps
// A write request is stored when the back end pops it from the queue; a compute request
// passes through queue, issue, drain and emit before its result is registered on the output.
// Compute requests are taken one at a time, set by the single shared
// multiply-accumulate walking the diagonals plus pipeline drain and emit; writes are
// taken back to back while the sequencer is idle.
// Reset (rst, synchronous): queue, sequencer and output valid clear; row_count = 1024,
// half_band = 1. Vector and band stores hold no reset value and must be written first.
module banded_matrix_vector_product (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bmv_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bmv_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [bmv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bmv_pkg::*;

  logic [RC_W-1:0] row_count;
  logic [HB_W-1:0] half_band;
  cfg_t            cfg;

  logic push;
  logic full;
  logic pop;
  logic q_valid;
  req_t push_req;
  req_t q_req;

  // Config registers; the user writes them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= RC_W'(MAX_ROWS);
      half_band <= HB_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data[RC_W-1:0];
        REG_HALF_BAND: half_band <= cfg_data[HB_W-1:0];
        default: ;
      endcase
    end
  end

  // Row counts past the store act as the full store. half_band is 3 bits and
  // cannot exceed MAX_HALF_BAND.
  always_comb begin
    cfg.row_count = (32'(row_count) > MAX_ROWS) ? RC_W'(MAX_ROWS) : row_count;
    cfg.half_band = half_band;
  end

  // Front end: classifies requests, drops mode three and out-of-range band writes.
  bmv_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .full     (full),
    .push     (push),
    .req      (push_req)
  );

  // Short queue decouples acceptance from the compute sequencer.
  bmv_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  // Back end: store writes, diagonal walk, MAC, saturation, output register.
  bmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A saturated result is one of the two rails.
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.product_sum == 32'sh7FFFFFFF) || (out_data.product_sum == 32'sh80000000))
    else $error("saturated result off the rails");

  // A mode three request never reaches the queue.
  a_drop_mode3: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.mode == 2'd3) |-> !push)
    else $error("mode three request queued");

  // Backpressure only comes from a full queue.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> full)
    else $error("input stalled with queue space");

endmodule
